// File: hdl/u8u2_pkg.sv
// Shared types and constants for the UTF-8 to UCS-2 name decoder.
package u8u2_pkg;

    // How many bytes of a multi-byte sequence are currently held.
    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE  = 2'd1;
    localparam logic [1:0] HELD_TWO  = 2'd2;

    // Replacement unit for bytes that cannot be decoded.
    localparam logic [15:0] QMARK = 16'h003F;

    // Everything one input byte produces: up to two units, then possibly the end beat.
    typedef struct packed {
        logic [1:0][15:0] unit;
        logic [1:0]       num_units;
        logic             end_mark;
        logic [6:0]       unit_count;
    } bundle_t;

endpackage

// File: hdl/u8u2_byte_if.sv
// Handshake channel carrying one UTF-8 byte per beat.
interface u8u2_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// File: hdl/u8u2_unit_if.sv
// Handshake channel carrying one UCS-2 result per beat.
interface u8u2_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        end_mark;
    logic [6:0]  unit_count;

    modport source (output valid, output code_unit, output end_mark, output unit_count,
                    input ready);
    modport sink   (input valid, input code_unit, input end_mark, input unit_count,
                    output ready);
endinterface

// File: hdl/u8u2_decode.sv
// Sequence state and single-byte decode into a bundle of results.
module u8u2_decode #(
    parameter int unsigned MAX_UNITS = 127
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        in_byte,
    input  logic              take,
    output u8u2_pkg::bundle_t bundle
);
    import u8u2_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_UNITS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_UNITS);

    logic [1:0]       held_reg,   held_next;
    logic [7:0]       lead_reg,   lead_next;
    logic [7:0]       second_reg, second_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;

    logic             cand0_vld, cand1_vld, fin;
    logic [15:0]      cand0, cand1;
    logic             keep0, keep1;
    logic [CNT_W-1:0] cnt_a, cnt_b;
    logic [CNT_W+6:0] cnt_ext;
    logic             lead_two, lead_three;

    assign lead_two   = (in_byte[7:5] == 3'b110);
    assign lead_three = (in_byte[7:4] == 4'b1110);

    always_comb
    begin
        cand0_vld   = 1'b0;
        cand1_vld   = 1'b0;
        cand0       = QMARK;
        cand1       = QMARK;
        fin         = 1'b0;
        held_next   = held_reg;
        lead_next   = lead_reg;
        second_next = second_reg;
        unique case (held_reg)
            HELD_NONE:
            begin
                if (in_byte == 8'h00)
                begin
                    fin = 1'b1;
                end
                else if (!in_byte[7])
                begin
                    cand0_vld = 1'b1;
                    cand0     = {8'h00, in_byte};
                end
                else if (lead_two || lead_three)
                begin
                    lead_next = in_byte;
                    held_next = HELD_ONE;
                end
                else
                begin
                    cand0_vld = 1'b1;
                end
            end
            HELD_ONE:
            begin
                if (in_byte == 8'h00)
                begin
                    cand0_vld = 1'b1;
                    fin       = 1'b1;
                end
                else if (lead_reg[7:5] == 3'b110)
                begin
                    cand0_vld = 1'b1;
                    cand0     = {5'b00000, lead_reg[4:0], in_byte[5:0]};
                    held_next = HELD_NONE;
                    lead_next = 8'h00;
                end
                else
                begin
                    second_next = in_byte;
                    held_next   = HELD_TWO;
                end
            end
            HELD_TWO:
            begin
                cand0_vld = 1'b1;
                if (in_byte == 8'h00)
                begin
                    // The held second byte is decoded again on its own.
                    cand1_vld = 1'b1;
                    cand1     = second_reg[7] ? QMARK : {8'h00, second_reg};
                    fin       = 1'b1;
                end
                else
                begin
                    cand0       = {lead_reg[3:0], second_reg[5:0], in_byte[5:0]};
                    held_next   = HELD_NONE;
                    lead_next   = 8'h00;
                    second_next = 8'h00;
                end
            end
            default:
            begin
                held_next = HELD_NONE;
            end
        endcase
    end

    // Units past the limit are dropped; the count saturates at the limit.
    assign keep0   = cand0_vld && (cnt_reg < CNT_MAX);
    assign cnt_a   = cnt_reg + CNT_W'(keep0);
    assign keep1   = cand1_vld && (cnt_a < CNT_MAX);
    assign cnt_b   = cnt_a + CNT_W'(keep1);
    assign cnt_ext = {7'b0000000, cnt_b};

    always_comb
    begin
        bundle.unit[0]    = keep0 ? cand0 : cand1;
        bundle.unit[1]    = cand1;
        bundle.num_units  = {1'b0, keep0} + {1'b0, keep1};
        bundle.end_mark   = fin;
        bundle.unit_count = cnt_ext[6:0];
        cnt_next          = fin ? '0 : cnt_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= HELD_NONE;
            lead_reg   <= 8'h00;
            second_reg <= 8'h00;
            cnt_reg    <= '0;
        end
        else if (take)
        begin
            if (fin)
            begin
                held_reg   <= HELD_NONE;
                lead_reg   <= 8'h00;
                second_reg <= 8'h00;
            end
            else
            begin
                held_reg   <= held_next;
                lead_reg   <= lead_next;
                second_reg <= second_next;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: hdl/u8u2_serial.sv
// Result register that holds one bundle and hands it out one beat at a time.
module u8u2_serial (
    input  logic              clk,
    input  logic              rst_n,
    input  u8u2_pkg::bundle_t bundle,
    input  logic              load,
    output logic              free,
    u8u2_unit_if.source       res
);
    import u8u2_pkg::*;

    logic [1:0][15:0] unit_reg;
    logic [1:0]       nu_reg;
    logic             end_reg;
    logic [6:0]       cnt_reg;
    logic [1:0]       idx_reg, idx_next;
    logic [1:0]       items;
    logic             pop, last, on_unit;

    assign items    = nu_reg + {1'b0, end_reg};
    assign on_unit  = (idx_reg < nu_reg);
    assign pop      = res.valid && res.ready;
    assign idx_next = idx_reg + 2'd1;
    assign last     = (idx_next == items);
    assign free     = !res.valid || (pop && last);

    assign res.valid      = (idx_reg < items);
    assign res.code_unit  = on_unit ? unit_reg[idx_reg[0]] : 16'h0000;
    assign res.end_mark   = !on_unit;
    assign res.unit_count = on_unit ? 7'd0 : cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
            nu_reg  <= 2'd0;
            end_reg <= 1'b0;
        end
        else if (load)
        begin
            idx_reg <= 2'd0;
            nu_reg  <= bundle.num_units;
            end_reg <= bundle.end_mark;
        end
        else if (pop)
        begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            unit_reg <= bundle.unit;
            cnt_reg  <= bundle.unit_count;
        end
    end

`ifndef SYNTHESIS
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= items)
        else $error("result index ran past the held bundle");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!res.valid || (pop && last)))
        else $error("bundle overwritten while results were pending");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.end_mark) |-> (idx_reg == nu_reg) && end_reg)
        else $error("end beat is not the last beat of its bundle");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !last && !load) |=> res.valid)
        else $error("bundle lost beats while draining");
`endif

endmodule

// File: hdl/utf8_to_ucs2_decoder_core.sv
// Top level of the UTF-8 to UCS-2 name decoder.
//
//   Channel      Modport  Beat payload                          Meaning
//   name_bytes   sink     in_byte[7:0]                          one UTF-8 byte, zero ends name
//   name_units   source   code_unit[15:0], end_mark, unit_count  one unit, or the end beat
//
// A byte is decoded in the cycle it is accepted and its results land in the
// result register at that edge; the first result is offered in the next cycle.
// A byte that yields zero or one result leaves room for the next byte in the
// very next cycle while name_units is ready, so the sustained rate is then one
// byte per cycle. A name end that yields two or three results holds the input
// until the single-beat output register has handed out its last beat.
// Reset clears the sequence state, the unit count and the result register's beat count.
// A stall on name_units holds the current beat and, once the register is full,
// holds name_bytes ready low.
module utf8_to_ucs2_decoder_core #(
    parameter int unsigned MAX_UNITS = 127
) (
    input  logic        clk,
    input  logic        rst_n,
    u8u2_byte_if.sink   name_bytes,
    u8u2_unit_if.source name_units
);
    import u8u2_pkg::*;

    bundle_t bundle;
    logic    take;
    logic    free;

    // The input is taken whenever the result register will be empty after
    // this edge, so the decode and the drain overlap.
    assign name_bytes.ready = free;
    assign take             = name_bytes.valid && free;

    u8u2_decode #(
        .MAX_UNITS (MAX_UNITS)
    ) u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_byte (name_bytes.in_byte),
        .take    (take),
        .bundle  (bundle)
    );

    u8u2_serial u_serial (
        .clk    (clk),
        .rst_n  (rst_n),
        .bundle (bundle),
        .load   (take),
        .free   (free),
        .res    (name_units)
    );

endmodule

// File: tb/utf8_to_ucs2_decoder_core_tb.sv
// Self-checking testbench for the UTF-8 to UCS-2 name decoder core.
module utf8_to_ucs2_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import u8u2_pkg::*;

    // One byte waiting to be sent. When hold_for_drain is set, the sender
    // waits until every expected result has come out before offering it.
    typedef struct {
        logic [7:0] value;
        bit         hold_for_drain;
    } name_byte_t;

    // One result beat as the decoder should give it.
    typedef struct {
        logic [15:0] code_unit;
        logic        end_mark;
        logic [6:0]  unit_count;
    } unit_beat_t;

    localparam int unsigned MAX_UNITS    = 127;
    localparam int          RANDOM_BYTES = 94;
    // A name end gives up to three beats through a single-beat register; the tail
    // wait after the last expected beat is long enough to catch a stray one.
    localparam int          TAIL_CYCLES  = 16;

    logic clk = 1'b0;
    logic rst_n;

    u8u2_byte_if name_bytes ();
    u8u2_unit_if name_units ();

    utf8_to_ucs2_decoder_core #(
        .MAX_UNITS(MAX_UNITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .name_bytes(name_bytes),
        .name_units(name_units)
    );

    always #2 clk = ~clk;

    // Bytes still to be sent, and the beats the decoder owes us, oldest first.
    name_byte_t byte_backlog[$];
    unit_beat_t expected_units[$];
    name_byte_t next_byte;
    unit_beat_t wanted;

    int total_bytes     = 0;
    int bytes_accepted  = 0;
    int names_closed    = 0;
    int units_dropped   = 0;
    int beats_checked   = 0;
    int mismatches      = 0;

    // Shadow copy of the decoder's sequence state.
    logic [1:0]  dec_held   = HELD_NONE;
    logic [7:0]  dec_lead   = '0;
    logic [7:0]  dec_second = '0;
    int unsigned dec_units  = 0;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // A unit only goes out while the name is below the unit limit. Past the
    // limit it is dropped, but the count stops growing too.
    function automatic void push_unit(input logic [15:0] unit);
        unit_beat_t beat;
        if (dec_units < MAX_UNITS)
        begin
            beat.code_unit  = unit;
            beat.end_mark   = 1'b0;
            beat.unit_count = '0;
            expected_units.push_back(beat);
            dec_units++;
        end
        else
        begin
            units_dropped++;
        end
    endfunction

    // The end beat carries the unit count and wipes the sequence state.
    function automatic void push_end();
        unit_beat_t beat;
        beat.code_unit  = '0;
        beat.end_mark   = 1'b1;
        beat.unit_count = 7'(dec_units);
        expected_units.push_back(beat);
        names_closed++;
        dec_held   = HELD_NONE;
        dec_lead   = '0;
        dec_second = '0;
        dec_units  = 0;
    endfunction

    // Work out every beat that one accepted byte causes.
    function automatic void decode_name_byte(input logic [7:0] b);
        case (dec_held)
            HELD_NONE:
            begin
                if (b == 8'h00)
                    push_end();
                else if (b < 8'h80)
                    push_unit({8'h00, b});
                // C0-DF opens a two-byte sequence, E0-EF a three-byte one.
                else if ((b & 8'hE0) == 8'hC0 || (b & 8'hF0) == 8'hE0)
                begin
                    dec_lead = b;
                    dec_held = HELD_ONE;
                end
                else
                    push_unit(QMARK);
            end
            HELD_ONE:
            begin
                if (b == 8'h00)
                begin
                    // The name stopped right after a lead byte.
                    push_unit(QMARK);
                    push_end();
                end
                else if ((dec_lead & 8'hE0) == 8'hC0)
                begin
                    // The following byte is not checked, only its low six bits count.
                    push_unit({5'b0, dec_lead[4:0], b[5:0]});
                    dec_held = HELD_NONE;
                    dec_lead = '0;
                end
                else
                begin
                    dec_second = b;
                    dec_held   = HELD_TWO;
                end
            end
            default:
            begin
                if (b == 8'h00)
                begin
                    // Three-byte lead plus one byte, then the end: the lead turns
                    // into '?' and the held byte is decoded again on its own.
                    push_unit(QMARK);
                    push_unit(dec_second < 8'h80 ? {8'h00, dec_second} : QMARK);
                    push_end();
                end
                else
                begin
                    push_unit({dec_lead[3:0], dec_second[5:0], b[5:0]});
                    dec_held   = HELD_NONE;
                    dec_lead   = '0;
                    dec_second = '0;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    function automatic void add_byte(input logic [7:0] value, input bit hold = 1'b0);
        name_byte_t item;
        item.value          = value;
        item.hold_for_drain = hold;
        byte_backlog.push_back(item);
        total_bytes++;
    endfunction

    // A following byte is usually a proper continuation byte, but sometimes any
    // nonzero byte, since the decoder does not look at the top two bits.
    function automatic logic [7:0] follow_byte();
        if ($urandom_range(3) == 0)
            return 8'($urandom_range(1, 255));
        return {2'b10, 6'($urandom())};
    endfunction

    // One character: plain ASCII, a two-byte sequence or a three-byte sequence.
    function automatic void add_char();
        int kind;
        kind = $urandom_range(2);
        if (kind == 0)
            add_byte(8'($urandom_range(1, 127)));
        else if (kind == 1)
        begin
            add_byte({3'b110, 5'($urandom())});
            add_byte(follow_byte());
        end
        else
        begin
            add_byte({4'b1110, 4'($urandom())});
            add_byte(follow_byte());
            add_byte(follow_byte());
        end
    endfunction

    // A well-formed name with random content. Now and then the sender must
    // let the decoder drain before the name starts.
    function automatic void add_clean_name(input int chars);
        if ($urandom_range(7) == 0)
            add_byte(8'($urandom_range(1, 127)), 1'b1);
        for (int i = 0; i < chars; i++)
            add_char();
        add_byte(8'h00);
    endfunction

    // A name that stops in the middle of a sequence.
    function automatic void add_broken_name();
        int chars;
        chars = $urandom_range(0, 3);
        for (int i = 0; i < chars; i++)
            add_char();
        if ($urandom_range(1) == 0)
            add_byte({3'b110, 5'($urandom())});
        else
        begin
            add_byte({4'b1110, 4'($urandom())});
            // The held second byte may be below 0x80 or not.
            if ($urandom_range(2) != 0)
                add_byte(8'($urandom_range(1, 255)));
        end
        add_byte(8'h00);
    endfunction

    // ------------------------------------------------------------------
    // Idling: receiver idles more in the first third, sender in the second,
    // and nobody idles in the last third of the bytes.
    // ------------------------------------------------------------------

    function automatic int run_phase();
        int p;
        p = (total_bytes == 0) ? 0 : (bytes_accepted * 3) / total_bytes;
        return (p > 2) ? 2 : p;
    endfunction

    function automatic int sender_idle_pct();
        case (run_phase())
            0:       return 36;
            1:       return 72;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct();
        case (run_phase())
            0:       return 72;
            1:       return 36;
            default: return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Byte driver. A beat stays on the channel until it is taken; the
    // prediction runs at the edge where the handshake completes.
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_bytes.valid   <= 1'b0;
            name_bytes.in_byte <= '0;
        end
        else
        begin
            if (name_bytes.valid && name_bytes.ready)
            begin
                decode_name_byte(name_bytes.in_byte);
                bytes_accepted++;
            end
            if (!name_bytes.valid || name_bytes.ready)
            begin
                if (byte_backlog.size() != 0
                    && $urandom_range(99) >= sender_idle_pct()
                    && !(byte_backlog[0].hold_for_drain && expected_units.size() != 0))
                begin
                    next_byte = byte_backlog.pop_front();
                    name_bytes.valid   <= 1'b1;
                    name_bytes.in_byte <= next_byte.value;
                end
                else
                begin
                    name_bytes.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor. Every taken beat is matched against the oldest
    // expectation, field by field; ready is redrawn every cycle.
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_units.ready <= 1'b0;
        end
        else
        begin
            if (name_units.valid && name_units.ready)
            begin
                if (expected_units.size() == 0)
                begin
                    $error("beat with nothing expected: code_unit=%h end_mark=%b count=%0d",
                           name_units.code_unit, name_units.end_mark, name_units.unit_count);
                    mismatches++;
                end
                else
                begin
                    wanted = expected_units.pop_front();
                    beats_checked++;
                    if (name_units.code_unit !== wanted.code_unit)
                    begin
                        $error("code_unit: expected %h, actual %h",
                               wanted.code_unit, name_units.code_unit);
                        mismatches++;
                    end
                    if (name_units.end_mark !== wanted.end_mark)
                    begin
                        $error("end_mark: expected %b, actual %b",
                               wanted.end_mark, name_units.end_mark);
                        mismatches++;
                    end
                    if (name_units.unit_count !== wanted.unit_count)
                    begin
                        $error("unit_count: expected %0d, actual %0d",
                               wanted.unit_count, name_units.unit_count);
                        mismatches++;
                    end
                end
            end
            name_units.ready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: build all bytes, reset once, then wait for the
    // decoder to finish everything it owes.
    // ------------------------------------------------------------------

    initial
    begin
        int random_start;

        rst_n              = 1'b0;
        name_bytes.valid   = 1'b0;
        name_bytes.in_byte = '0;
        name_units.ready   = 1'b0;

        // Directed part. ASCII 0x41 and 0x7F, the smallest and largest two- and
        // three-byte sequences, bad lead bytes, a following byte that is not a
        // continuation byte, and a name that ends right after a lead.
        add_byte(8'h41);
        add_byte(8'h7F);
        add_byte(8'hC0);
        add_byte(8'h80);
        add_byte(8'hDF);
        add_byte(8'hBF);
        add_byte(8'hE0);
        add_byte(8'h80);
        add_byte(8'h80);
        add_byte(8'hEF);
        add_byte(8'hBF);
        add_byte(8'hBF);
        add_byte(8'h80);
        add_byte(8'hF0);
        add_byte(8'hFF);
        add_byte(8'hC3);
        add_byte(8'h41);
        add_byte(8'hC5);
        add_byte(8'h00);
        // Three-byte lead and a low second byte, then the end. The sender
        // holds off here until the decoder has drained completely.
        add_byte(8'hE2, 1'b1);
        add_byte(8'h41);
        add_byte(8'h00);
        // Same, with a high second byte that turns into a second '?'.
        add_byte(8'hE2);
        add_byte(8'hA5);
        add_byte(8'h00);
        // An empty name.
        add_byte(8'h00);

        // Random part: mostly well-formed names, some broken ones and some
        // raw noise.
        random_start = total_bytes;
        while (total_bytes - random_start < RANDOM_BYTES)
        begin
            int pick;
            pick = $urandom_range(99);
            if (pick < 70)
                add_clean_name($urandom_range(0, 6));
            else if (pick < 85)
                add_broken_name();
            else
            begin
                int burst;
                burst = $urandom_range(1, 6);
                for (int i = 0; i < burst; i++)
                    add_byte(8'($urandom_range(0, 255)));
            end
        end
        // Leave the decoder at a clean name boundary.
        add_byte(8'h00);

        repeat (11) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        do
            @(posedge clk);
        while (byte_backlog.size() != 0 || name_bytes.valid || expected_units.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d bytes in %0d names, %0d result beats checked,",
                 bytes_accepted, names_closed, beats_checked);
        $display("%0d units dropped past the limit of %0d, %0d mismatches.",
                 units_dropped, MAX_UNITS, mismatches);
        if (mismatches == 0 && expected_units.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: ends the run as a failure long after the slowest correct run would finish.
    initial
    begin
        #1ms;
        $display("tb: failure");
        $finish;
    end

endmodule
